/* sv/hevl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hevl_pkg
// Shared widths, stage payload types and the check-count function for the
// variable-length Hamming encoder.
// ----------------------------------------------------------------------------
package hevl_pkg;

  localparam int MAX_DATA_BITS = 57;
  localparam int MSG_W         = 57;
  localparam int LEN_W         = 6;
  localparam int CODE_W        = 63;
  localparam int CNT_W         = 3;
  localparam int CHECK_MAX     = 6;

  // Stage 1 -> stage 2: masked message plus the length decode.
  typedef struct packed {
    logic [MSG_W-1:0] data;
    logic [LEN_W-1:0] code_length;
    logic [CNT_W-1:0] check_count;
  } front_t;

  // Stage 2 -> stage 3: finished code word plus the length decode.
  typedef struct packed {
    logic [CODE_W-1:0] code_word;
    logic [LEN_W-1:0]  code_length;
    logic [CNT_W-1:0]  check_count;
  } check_t;

  // Least r >= 1 with 2^r >= len + r + 1; len is already clamped.
  function automatic logic [CNT_W-1:0] check_bits(input logic [LEN_W-1:0] len);
    logic [CNT_W-1:0] r;
    r = CNT_W'(1);
    for (int i = 1; i < CHECK_MAX; i++) begin
      if ((7'(1) << i) < (7'(len) + 7'(i) + 7'(1))) begin
        r = CNT_W'(i + 1);
      end
    end
    return r;
  endfunction

endpackage

/* sv/hevl_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hevl_front
// Stage 1: clamp the length, drop message bits past it, decode r and n.
// ----------------------------------------------------------------------------
module hevl_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [hevl_pkg::MSG_W-1:0]   message,
  input  logic [hevl_pkg::LEN_W-1:0]   msg_length,
  input  logic                         take,
  output logic                         ready,
  output logic                         valid,
  output hevl_pkg::front_t             q
);

  logic [hevl_pkg::LEN_W-1:0] len_clamped;
  logic [hevl_pkg::MSG_W-1:0] keep_mask;
  logic [hevl_pkg::CNT_W-1:0] r_count;
  hevl_pkg::front_t           q_next;

  assign ready = !valid || take;

  always_comb begin
    if (msg_length > hevl_pkg::LEN_W'(hevl_pkg::MAX_DATA_BITS)) begin
      len_clamped = hevl_pkg::LEN_W'(hevl_pkg::MAX_DATA_BITS);
    end else begin
      len_clamped = msg_length;
    end
    keep_mask          = (hevl_pkg::MSG_W'(1) << len_clamped) - hevl_pkg::MSG_W'(1);
    r_count            = hevl_pkg::check_bits(len_clamped);
    q_next.data        = message & keep_mask;
    q_next.check_count = r_count;
    q_next.code_length = len_clamped + hevl_pkg::LEN_W'(r_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && in_valid) begin
      q <= q_next;
    end
  end

endmodule

/* sv/hevl_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hevl_check
// Stage 2: scatter data bits to non-power-of-two positions, form check bits.
// ----------------------------------------------------------------------------
module hevl_check (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  hevl_pkg::front_t d,
  input  logic             take,
  output logic             ready,
  output logic             valid,
  output hevl_pkg::check_t q
);

  // Code positions (1-based) covered by check bit k, data positions only.
  function automatic logic [hevl_pkg::CODE_W-1:0] cover_mask(input int k);
    logic [hevl_pkg::CODE_W-1:0] m;
    m = '0;
    for (int pos = 1; pos <= hevl_pkg::CODE_W; pos++) begin
      if (((pos >> k) & 1) == 1 && (pos & (pos - 1)) != 0) begin
        m[pos-1] = 1'b1;
      end
    end
    return m;
  endfunction

  logic [hevl_pkg::CODE_W-1:0] data_word;
  logic [hevl_pkg::CODE_W-1:0] code_next;
  hevl_pkg::check_t            q_next;

  assign ready = !valid || take;

  // Fixed wiring: data bit j lands on the j-th non-power-of-two position.
  always_comb begin
    int j;
    data_word = '0;
    j = 0;
    for (int pos = 1; pos <= hevl_pkg::CODE_W; pos++) begin
      if ((pos & (pos - 1)) != 0) begin
        if (j < hevl_pkg::MSG_W) begin
          data_word[pos-1] = d.data[j];
        end
        j++;
      end
    end
  end

  // Unused check bits cover only zero positions, so all six are formed.
  always_comb begin
    code_next = data_word;
    for (int k = 0; k < hevl_pkg::CHECK_MAX; k++) begin
      code_next[(1 << k) - 1] = ^(data_word & cover_mask(k));
    end
    q_next.code_word   = code_next;
    q_next.code_length = d.code_length;
    q_next.check_count = d.check_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && in_valid) begin
      q <= q_next;
    end
  end

endmodule

/* sv/hevl_parity.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hevl_parity
// Stage 3: overall parity of the code word and the output register.
// ----------------------------------------------------------------------------
module hevl_parity (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  hevl_pkg::check_t            d,
  input  logic                        take,
  output logic                        ready,
  output logic                        valid,
  output logic [hevl_pkg::CODE_W-1:0] code_word,
  output logic [hevl_pkg::LEN_W-1:0]  code_length,
  output logic [hevl_pkg::CNT_W-1:0]  check_count,
  output logic                        overall_parity
);

  assign ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && in_valid) begin
      code_word      <= d.code_word;
      code_length    <= d.code_length;
      check_count    <= d.check_count;
      overall_parity <= ^d.code_word;
    end
  end

endmodule

/* sv/hamming_encoder_variable_length_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamming_encoder_variable_length_unit
// Variable-length even-parity Hamming encoder with extended parity bit.
// ----------------------------------------------------------------------------
// Encodes a message of up to 57 bits (length above 57 is clamped, bits past
// the length are dropped) into a Hamming code word with the least number r of
// check bits such that 2^r >= m + r + 1. Code position i+1 appears on
// code_word bit i; bits at and above code_length read zero. A zero length
// gives r = 1, code_length = 1 and an all-zero word. One transaction enters
// per cycle while msg_stall is low; its result passes through the three
// register stages in order: length decode and masking, bit scatter with the
// check-bit XOR trees, then the overall-parity tree in the output register.
// A stall on the result side holds every stage that is full and lets empty
// stages fill, so bubbles are squeezed out before msg_stall rises.
// ----------------------------------------------------------------------------
module hamming_encoder_variable_length_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        msg_valid,
  output logic                        msg_stall,
  input  logic [hevl_pkg::MSG_W-1:0]  message,
  input  logic [hevl_pkg::LEN_W-1:0]  msg_length,
  output logic                        code_valid,
  input  logic                        code_stall,
  output logic [hevl_pkg::CODE_W-1:0] code_word,
  output logic [hevl_pkg::LEN_W-1:0]  code_length,
  output logic [hevl_pkg::CNT_W-1:0]  check_count,
  output logic                        overall_parity
);

  logic             front_ready;
  logic             front_valid;
  hevl_pkg::front_t front_q;
  logic             check_ready;
  logic             check_valid;
  hevl_pkg::check_t check_q;
  logic             parity_ready;

  // Stage 1: clamp, mask, decode r and code length.
  hevl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (msg_valid),
    .message    (message),
    .msg_length (msg_length),
    .take       (check_ready),
    .ready      (front_ready),
    .valid      (front_valid),
    .q          (front_q)
  );

  // Stage 2: place data bits and form the check bits.
  hevl_check u_check (
    .clk      (clk),
    .rst      (rst),
    .in_valid (front_valid),
    .d        (front_q),
    .take     (parity_ready),
    .ready    (check_ready),
    .valid    (check_valid),
    .q        (check_q)
  );

  // Stage 3: overall parity; hold the result until it is taken.
  hevl_parity u_parity (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (check_valid),
    .d              (check_q),
    .take           (!code_stall),
    .ready          (parity_ready),
    .valid          (code_valid),
    .code_word      (code_word),
    .code_length    (code_length),
    .check_count    (check_count),
    .overall_parity (overall_parity)
  );

  // Stall the source only when the first stage is full and cannot advance.
  assign msg_stall = !front_ready;

endmodule

/* test/tb_hamming_encoder_variable_length_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hamming_encoder_variable_length_unit
// Self-checking bench for the variable-length Hamming encoder.
// ----------------------------------------------------------------------------
// Drives messages and lengths through the valid/stall input channel and
// compares every code word transaction against a behavioral encoder kept
// inside the bench. Covers zero and clamped lengths, bits past the length,
// the largest code word, and random traffic under four pacing modes: free
// running, sparse sender, stalling receiver, and both at once.
// ----------------------------------------------------------------------------
module tb_hamming_encoder_variable_length_unit;

  // One expected code word transaction.
  typedef struct packed {
    logic [hevl_pkg::CODE_W-1:0] word;
    logic [hevl_pkg::LEN_W-1:0]  length;
    logic [hevl_pkg::CNT_W-1:0]  checks;
    logic                        parity;
  } code_result_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        msg_valid = 1'b0;
  logic                        msg_stall;
  logic [hevl_pkg::MSG_W-1:0]  message = '0;
  logic [hevl_pkg::LEN_W-1:0]  msg_length = '0;
  logic                        code_valid;
  logic                        code_stall = 1'b0;
  logic [hevl_pkg::CODE_W-1:0] code_word;
  logic [hevl_pkg::LEN_W-1:0]  code_length;
  logic [hevl_pkg::CNT_W-1:0]  check_count;
  logic                        overall_parity;

  code_result_t expected_codes[$];
  int           messages_sent = 0;
  int           words_checked = 0;
  int           mismatches = 0;
  // Pacing knobs, in percent of cycles.
  int           sender_idle_pct = 0;
  int           receiver_stall_pct = 0;

  hamming_encoder_variable_length_unit dut (
    .clk            (clk),
    .rst            (rst),
    .msg_valid      (msg_valid),
    .msg_stall      (msg_stall),
    .message        (message),
    .msg_length     (msg_length),
    .code_valid     (code_valid),
    .code_stall     (code_stall),
    .code_word      (code_word),
    .code_length    (code_length),
    .check_count    (check_count),
    .overall_parity (overall_parity)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard limit on the run; far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("hamming_encoder_variable_length_unit: mismatch");
    $finish;
  end

  // Encode one message the long way: clamp the length, grow r until the
  // Hamming bound holds, scatter data onto non-power-of-two positions, then
  // fill each power-of-two position with even parity over its coverage set.
  function automatic code_result_t encode_hamming(
      input logic [hevl_pkg::MSG_W-1:0] msg,
      input logic [hevl_pkg::LEN_W-1:0] raw_len);
    code_result_t                res;
    int                          len;
    int                          r;
    int                          n;
    int                          j;
    int                          p;
    logic [hevl_pkg::CODE_W-1:0] cw;
    logic                        chk;
    logic                        par;
    len = (raw_len > hevl_pkg::MAX_DATA_BITS) ? hevl_pkg::MAX_DATA_BITS : int'(raw_len);
    r = 1;
    while ((1 << r) < len + r + 1) r++;
    n = len + r;
    cw = '0;
    j = 0;
    for (int pos = 1; pos <= n; pos++) begin
      if ((pos & (pos - 1)) != 0) begin
        cw[pos-1] = msg[j];
        j++;
      end
    end
    for (int k = 0; k < r; k++) begin
      p = 1 << k;
      if (p <= n) begin
        chk = 1'b0;
        for (int pos = 1; pos <= n; pos++) begin
          if (pos != p && (pos & p) != 0) chk ^= cw[pos-1];
        end
        cw[p-1] = chk;
      end
    end
    par = 1'b0;
    for (int pos = 0; pos < n; pos++) par ^= cw[pos];
    res.word   = cw;
    res.length = hevl_pkg::LEN_W'(n);
    res.checks = hevl_pkg::CNT_W'(r);
    res.parity = par;
    return res;
  endfunction

  // Receiver side: stall at the current rate, decided fresh each edge.
  always @(posedge clk) begin
    code_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  // Result checker: every accepted code word must match the oldest prediction.
  always @(posedge clk) begin : check_results
    code_result_t want;
    if (!rst && code_valid && !code_stall) begin
      if (expected_codes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: code word %h with nothing outstanding", code_word);
      end else begin
        want = expected_codes.pop_front();
        words_checked++;
        if (code_word !== want.word || code_length !== want.length ||
            check_count !== want.checks || overall_parity !== want.parity) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: word %0d: exp word=%h len=%0d r=%0d par=%b",
                     words_checked, want.word, want.length, want.checks, want.parity);
            $display("       got word=%h len=%0d r=%0d par=%b",
                     code_word, code_length, check_count, overall_parity);
          end
        end
      end
    end
  end

  // Idle the sender cycle by cycle at its current rate, then present one
  // message and hold it until accepted. Valid stays high between
  // back-to-back transactions.
  task automatic send_message(input logic [hevl_pkg::MSG_W-1:0] msg,
                              input logic [hevl_pkg::LEN_W-1:0] len);
    while ($urandom_range(99) < sender_idle_pct) begin
      msg_valid <= 1'b0;
      @(posedge clk);
    end
    msg_valid  <= 1'b1;
    message    <= msg;
    msg_length <= len;
    do @(posedge clk); while (msg_stall !== 1'b0);
    expected_codes.insert(expected_codes.size(), encode_hamming(msg, len));
    messages_sent++;
  endtask

  // Corner lengths and patterns: zero length, the clamp, dropped high bits,
  // the r boundaries, and the full 63-bit word.
  task automatic test_directed();
    logic [hevl_pkg::MSG_W-1:0] ones;
    logic [hevl_pkg::MSG_W-1:0] alt;
    ones = '1;
    alt  = hevl_pkg::MSG_W'({29{2'b01}});
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    send_message(ones, 6'd0);
    send_message('0, 6'd0);
    send_message(ones, 6'd1);
    send_message(hevl_pkg::MSG_W'(1), 6'd1);
    send_message(ones, 6'd2);
    send_message(ones, 6'd4);
    send_message(ones, 6'd5);
    send_message(alt, 6'd11);
    send_message(~alt, 6'd12);
    send_message(ones, 6'd26);
    send_message(alt, 6'd27);
    send_message(ones, 6'd56);
    send_message(ones, 6'd57);
    send_message('0, 6'd57);
    send_message(alt, 6'd57);
    send_message(~alt, 6'd57);
    send_message(hevl_pkg::MSG_W'(1) << (hevl_pkg::MSG_W - 1), 6'd57);
    send_message(ones, 6'd58);
    send_message(alt, 6'd63);
    send_message('0, 6'd63);
    send_message(ones, 6'd3);
  endtask

  // Random traffic: mostly legal lengths, with zero and over-length mixed in;
  // messages are random, all ones, or a single set bit.
  task automatic run_random(input int count, input int idle_pct, input int stall_pct);
    logic [hevl_pkg::MSG_W-1:0] msg;
    logic [hevl_pkg::LEN_W-1:0] len;
    int                         pick;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (count) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) len = hevl_pkg::LEN_W'($urandom_range(1, hevl_pkg::MAX_DATA_BITS));
      else if (pick == 6) len = ($urandom_range(0, 1) == 0) ? 6'd0 : 6'd57;
      else len = hevl_pkg::LEN_W'($urandom_range(0, 63));
      pick = $urandom_range(0, 7);
      if (pick == 0) msg = '1;
      else if (pick == 1) msg = hevl_pkg::MSG_W'(1) << $urandom_range(0, hevl_pkg::MSG_W - 1);
      else msg = hevl_pkg::MSG_W'({$urandom, $urandom});
      send_message(msg, len);
    end
  endtask

  task automatic test_free_running();
    run_random(190, 0, 0);
  endtask

  task automatic test_sparse_sender();
    run_random(180, 59, 0);
  endtask

  task automatic test_stalling_receiver();
    run_random(180, 0, 59);
  endtask

  task automatic test_both_throttled();
    run_random(180, 29, 29);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_free_running();
    test_sparse_sender();
    test_stalling_receiver();
    test_both_throttled();
    msg_valid <= 1'b0;
    // Drain the pipe, then let the three stages idle before the summary.
    while (expected_codes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Encoded %0d messages (lengths 0..63, clamp and dropped bits included);",
             messages_sent);
    $display("compared %0d code words under free, sparse, stalled and mixed pacing.",
             words_checked);
    if (mismatches == 0) begin
      $display("hamming_encoder_variable_length_unit: match");
    end else begin
      $display("%0d bad code words", mismatches);
      $display("hamming_encoder_variable_length_unit: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/hevl_pkg.sv
sv/hevl_front.sv
sv/hevl_check.sv
sv/hevl_parity.sv
sv/hamming_encoder_variable_length_unit.sv
test/tb_hamming_encoder_variable_length_unit.sv
